// ----- src/ifhe_pkg.sv -----
package ifhe_pkg;

    localparam int PAYLOAD_BYTES_DEF = 12;
    localparam int FLOAT_OFFSET_DEF  = 8;
    localparam int QUEUE_DEPTH       = 2;

    localparam int IDX_W  = 4;
    localparam int HEAD_W = 9;

    localparam logic [7:0] HDR_BYTE0 = 8'd250;
    localparam logic [7:0] HDR_BYTE1 = 8'd255;
    localparam logic [7:0] HDR_BYTE2 = 8'd50;
    localparam logic [7:0] HDR_BYTE3 = 8'd12;

    localparam logic [7:0] EXP_BIAS = 8'd127;
    localparam logic [7:0] EXP_SPECIAL = 8'hFF;
    // Biased exponent of 2^31; anything at or above it does not fit.
    localparam logic [7:0] EXP_LIMIT = 8'd158;
    localparam logic [7:0] EXP_TOP = 8'd157;

    localparam logic [HEAD_W:0] DEG_FULL = 10'd360;

    localparam int MAG_W         = 32;
    localparam int BITS_PER_STEP = 4;
    localparam int MOD_STEPS     = MAG_W / BITS_PER_STEP;
    localparam int STEP_CNT_W    = $clog2(MOD_STEPS);

    typedef logic [31:0] float_word_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

// ----- src/imu_frame_heading_extractor_unit.sv -----
// Channel  | Ports                                  | Carries
// ---------+----------------------------------------+-------------------------------
// input    | s_valid, s_ready, s_rx_byte            | one received link byte
// result   | m_valid, m_ready, m_heading,           | one heading per frame, with
//          | m_out_of_range                         | the out of range flag
//
// The parser takes one byte per cycle and never waits on the converter except on the
// last payload byte of a frame, and then only while the frame queue is full.
// Each queued frame passes through the converter in order: one decode and shift step, then
// a fold of 4 bits at a time into the remainder modulo 360, then the output register.
// Synchronous active-low reset returns the parser to header search and empties the queue.
// A stalled result holds in the output register while the parser keeps accepting bytes.
module imu_frame_heading_extractor_unit #(
    parameter int PAYLOAD_BYTES = ifhe_pkg::PAYLOAD_BYTES_DEF,
    parameter int FLOAT_OFFSET  = ifhe_pkg::FLOAT_OFFSET_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_rx_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ifhe_pkg::HEAD_W-1:0] m_heading,
    output logic                        m_out_of_range
);

    ifhe_pkg::q_status_t   q_status;
    logic                  q_push;
    logic                  q_pop;
    ifhe_pkg::float_word_t q_push_data;
    ifhe_pkg::float_word_t q_pop_data;

    ifhe_parser #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES),
        .FLOAT_OFFSET (FLOAT_OFFSET)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .q_status   (q_status),
        .q_push     (q_push),
        .q_push_data(q_push_data)
    );

    ifhe_queue #(
        .DEPTH(ifhe_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data(q_push_data),
        .pop      (q_pop),
        .pop_data (q_pop_data),
        .status   (q_status)
    );

    ifhe_convert u_convert (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_status      (q_status),
        .q_pop_data    (q_pop_data),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_heading     (m_heading),
        .m_out_of_range(m_out_of_range)
    );

endmodule

// ----- src/ifhe_queue.sv -----
module ifhe_queue #(
    parameter int DEPTH = ifhe_pkg::QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  ifhe_pkg::float_word_t push_data,
    input  logic                  pop,
    output ifhe_pkg::float_word_t pop_data,
    output ifhe_pkg::q_status_t   status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ifhe_pkg::float_word_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CW'(DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- src/ifhe_parser.sv -----
module ifhe_parser #(
    parameter int PAYLOAD_BYTES = ifhe_pkg::PAYLOAD_BYTES_DEF,
    parameter int FLOAT_OFFSET  = ifhe_pkg::FLOAT_OFFSET_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_rx_byte,
    input  ifhe_pkg::q_status_t   q_status,
    output logic                  q_push,
    output ifhe_pkg::float_word_t q_push_data
);

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_H1       = 6'b000010,
        PH_H2       = 6'b000100,
        PH_H3       = 6'b001000,
        PH_PAYLOAD  = 6'b010000,
        PH_CHECKSUM = 6'b100000
    } phase_t;

    localparam logic [ifhe_pkg::IDX_W-1:0] LAST_IDX = ifhe_pkg::IDX_W'(PAYLOAD_BYTES - 1);
    localparam logic [ifhe_pkg::IDX_W:0] FLOAT_LO = (ifhe_pkg::IDX_W + 1)'(FLOAT_OFFSET);
    localparam logic [ifhe_pkg::IDX_W:0] FLOAT_HI = (ifhe_pkg::IDX_W + 1)'(FLOAT_OFFSET + 4);

    phase_t                       phase_reg, phase_next;
    logic [ifhe_pkg::IDX_W-1:0]   idx_reg, idx_next;
    ifhe_pkg::float_word_t        float_reg, float_next;
    ifhe_pkg::float_word_t        float_shifted;
    logic                         accept;
    logic                         last_byte;
    logic                         in_window;
    phase_t                       restart;

    assign last_byte = (idx_reg >= LAST_IDX);
    assign in_window = ({1'b0, idx_reg} >= FLOAT_LO) && ({1'b0, idx_reg} < FLOAT_HI);
    assign float_shifted = in_window ? {float_reg[23:0], s_rx_byte} : float_reg;

    // Only the last payload byte of a frame needs room in the queue.
    assign s_ready = !((phase_reg == PH_PAYLOAD) && last_byte && q_status.full);
    assign accept  = s_valid && s_ready;

    assign q_push      = accept && (phase_reg == PH_PAYLOAD) && last_byte;
    assign q_push_data = float_shifted;

    // A byte that breaks the header may itself open a new frame.
    assign restart = (s_rx_byte == ifhe_pkg::HDR_BYTE0) ? PH_H1 : PH_IDLE;

    always_comb begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        float_next = float_reg;
        if (accept) begin
            case (phase_reg)
                PH_H1: begin
                    phase_next = (s_rx_byte == ifhe_pkg::HDR_BYTE1) ? PH_H2 : restart;
                end
                PH_H2: begin
                    phase_next = (s_rx_byte == ifhe_pkg::HDR_BYTE2) ? PH_H3 : restart;
                end
                PH_H3: begin
                    if (s_rx_byte == ifhe_pkg::HDR_BYTE3) begin
                        phase_next = PH_PAYLOAD;
                        idx_next   = '0;
                        float_next = '0;
                    end else begin
                        phase_next = restart;
                    end
                end
                PH_PAYLOAD: begin
                    float_next = float_shifted;
                    if (last_byte) begin
                        idx_next   = '0;
                        phase_next = PH_CHECKSUM;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                PH_CHECKSUM: begin
                    phase_next = PH_IDLE;
                end
                default: begin
                    phase_next = restart;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            idx_reg   <= '0;
            float_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            float_reg <= float_next;
        end
    end

endmodule

// ----- src/ifhe_convert.sv -----
module ifhe_convert (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ifhe_pkg::q_status_t           q_status,
    input  ifhe_pkg::float_word_t         q_pop_data,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ifhe_pkg::HEAD_W-1:0]   m_heading,
    output logic                          m_out_of_range
);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_MOD  = 3'b010,
        B_OUT  = 3'b100
    } back_state_t;

    localparam int HW = ifhe_pkg::HEAD_W;

    back_state_t                          state_reg, state_next;
    logic [ifhe_pkg::MAG_W-1:0]           mag_reg, mag_next;
    logic [HW-1:0]                        rem_reg, rem_next;
    logic [ifhe_pkg::STEP_CNT_W-1:0]      cnt_reg, cnt_next;
    logic                                 neg_reg, neg_next;
    logic                                 oor_reg, oor_next;
    logic [HW-1:0]                        head_reg, head_next;

    logic [7:0]                           expf;
    logic [4:0]                           shamt;
    logic [30:0]                          mag_shifted;
    logic                                 is_special;
    logic                                 is_small;
    logic                                 is_big;
    logic [HW-1:0]                        rem_step;
    logic [HW:0]                          trial;
    logic [HW-1:0]                        rem_fix;

    assign expf        = q_pop_data[30:23];
    assign is_special  = (expf == ifhe_pkg::EXP_SPECIAL);
    assign is_small    = (expf < ifhe_pkg::EXP_BIAS);
    assign is_big      = (expf >= ifhe_pkg::EXP_LIMIT);
    // The mantissa sits left-justified in 31 bits, so the integer part is a right shift.
    assign shamt       = 5'(ifhe_pkg::EXP_TOP - expf);
    assign mag_shifted = {1'b1, q_pop_data[22:0], 7'b0} >> shamt;

    // Four bits of the magnitude enter the running remainder per cycle.
    always_comb begin
        rem_step = rem_reg;
        trial    = '0;
        for (int i = 0; i < ifhe_pkg::BITS_PER_STEP; i++) begin
            trial = {rem_step, mag_reg[ifhe_pkg::MAG_W-1-i]};
            if (trial >= ifhe_pkg::DEG_FULL) begin
                trial = trial - ifhe_pkg::DEG_FULL;
            end
            rem_step = trial[HW-1:0];
        end
    end

    assign rem_fix = (neg_reg && rem_step != '0)
                   ? HW'(ifhe_pkg::DEG_FULL - {1'b0, rem_step}) : rem_step;

    assign q_pop = (state_reg == B_IDLE) && !q_status.empty;

    always_comb begin
        state_next = state_reg;
        mag_next   = mag_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        oor_next   = oor_reg;
        head_next  = head_reg;
        case (state_reg)
            B_IDLE: begin
                if (!q_status.empty) begin
                    mag_next   = (is_special || is_small || is_big)
                               ? '0 : {1'b0, mag_shifted};
                    oor_next   = is_special || (!is_small && is_big);
                    neg_next   = q_pop_data[31];
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = B_MOD;
                end
            end
            B_MOD: begin
                mag_next = mag_reg << ifhe_pkg::BITS_PER_STEP;
                rem_next = rem_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ifhe_pkg::STEP_CNT_W'(ifhe_pkg::MOD_STEPS - 1)) begin
                    head_next  = rem_fix;
                    state_next = B_OUT;
                end
            end
            B_OUT: begin
                if (m_ready) begin
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg  <= mag_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        oor_reg  <= oor_next;
        head_reg <= head_next;
    end

    assign m_valid        = (state_reg == B_OUT);
    assign m_heading      = head_reg;
    assign m_out_of_range = oor_reg;

endmodule

// ----- src/ifhe_checker.sv -----
module ifhe_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic [7:0]                  s_rx_byte,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [ifhe_pkg::HEAD_W-1:0] m_heading,
    input logic                        m_out_of_range
);

    logic unused_in;
    assign unused_in = s_valid ^ s_ready ^ (^s_rx_byte);

    // A heading is always whole degrees below a full turn.
    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_heading < 9'd360))
        else $error("heading outside 0 to 359");

    // An out of range value reports heading zero.
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_of_range) |-> (m_heading == '0))
        else $error("out of range result with nonzero heading");

    // Reset drops any pending result.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_heading) && $stable(m_out_of_range)))
        else $error("stalled result changed");

endmodule

bind imu_frame_heading_extractor_unit ifhe_checker u_ifhe_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_rx_byte     (s_rx_byte),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_heading     (m_heading),
    .m_out_of_range(m_out_of_range)
);

// ----- tb/imu_frame_heading_extractor_unit_tb.sv -----
module imu_frame_heading_extractor_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RANDOM_BYTES = 650;
    localparam int DRAIN_CYCLES     = 40;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int HOLD_AFTER       = 10;
    localparam int NUM_CORNERS      = 20;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_GOT_FA   = 3'd1,
        ST_GOT_FF   = 3'd2,
        ST_GOT_32   = 3'd3,
        ST_PAYLOAD  = 3'd4,
        ST_CHECKSUM = 3'd5
    } parse_state_t;

    typedef struct packed {
        logic [ifhe_pkg::HEAD_W-1:0] deg;
        logic                        oor;
    } heading_t;

    logic                        aclk           = 1'b0;
    logic                        aresetn        = 1'b0;
    logic                        s_valid        = 1'b0;
    logic                        s_ready;
    logic [7:0]                  s_rx_byte      = 8'd0;
    logic                        m_valid;
    logic                        m_ready        = 1'b0;
    logic [ifhe_pkg::HEAD_W-1:0] m_heading;
    logic                        m_out_of_range;

    imu_frame_heading_extractor_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_heading     (m_heading),
        .m_out_of_range(m_out_of_range)
    );

    logic [7:0]   bytes_to_send[$];
    heading_t     expected_headings[$];
    int           error_count   = 0;
    int           bytes_sent    = 0;
    int           headings_seen = 0;

    // Parser copy used for prediction.
    parse_state_t parse_st = ST_IDLE;
    int           pay_idx  = 0;
    logic [31:0]  flt_word = '0;

    logic [31:0] corner_floats [NUM_CORNERS] = '{
        32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF, 32'h3F00_0000,
        32'hBF7F_FFFF, 32'h3F80_0000, 32'hBF80_0000, 32'h43B4_0000, 32'hC3B4_0000,
        32'hC3B4_8000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
        32'h4F00_0000, 32'hCF00_0000, 32'h4EFF_FFFF, 32'hCEFF_FFFF, 32'h4B00_0000
    };

    initial begin
        forever #1 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic heading_t wrap_heading(input logic [31:0] bits);
        heading_t    res;
        logic [31:0] mant;
        logic [31:0] mag;
        int          e;
        int          rem;
        res  = '0;
        mant = {8'd0, 1'b1, bits[22:0]};
        e    = int'(bits[30:23]) - int'(ifhe_pkg::EXP_BIAS);
        if (bits[30:23] == ifhe_pkg::EXP_SPECIAL || bits[30:23] >= ifhe_pkg::EXP_LIMIT) begin
            res.oor = 1'b1;
        end else if (e >= 0) begin
            if (e >= 23) mag = mant << (e - 23);
            else mag = mant >> (23 - e);
            rem = int'(mag % 32'(ifhe_pkg::DEG_FULL));
            if (bits[31] && rem != 0) rem = int'(ifhe_pkg::DEG_FULL) - rem;
            res.deg = rem[ifhe_pkg::HEAD_W-1:0];
        end
        return res;
    endfunction

    function automatic parse_state_t restart_state(input logic [7:0] b);
        return (b == ifhe_pkg::HDR_BYTE0) ? ST_GOT_FA : ST_IDLE;
    endfunction

    task automatic advance_parser(input logic [7:0] b);
        case (parse_st)
            ST_GOT_FA: parse_st = (b == ifhe_pkg::HDR_BYTE1) ? ST_GOT_FF : restart_state(b);
            ST_GOT_FF: parse_st = (b == ifhe_pkg::HDR_BYTE2) ? ST_GOT_32 : restart_state(b);
            ST_GOT_32: begin
                if (b == ifhe_pkg::HDR_BYTE3) begin
                    parse_st = ST_PAYLOAD;
                    pay_idx  = 0;
                    flt_word = '0;
                end else begin
                    parse_st = restart_state(b);
                end
            end
            ST_PAYLOAD: begin
                if (pay_idx >= ifhe_pkg::FLOAT_OFFSET_DEF
                        && pay_idx < ifhe_pkg::FLOAT_OFFSET_DEF + 4)
                    flt_word = {flt_word[23:0], b};
                if (pay_idx + 1 >= ifhe_pkg::PAYLOAD_BYTES_DEF) begin
                    expected_headings.push_back(wrap_heading(flt_word));
                    pay_idx  = 0;
                    parse_st = ST_CHECKSUM;
                end else begin
                    pay_idx = pay_idx + 1;
                end
            end
            ST_CHECKSUM: parse_st = ST_IDLE;
            default: parse_st = restart_state(b);
        endcase
    endtask

    function automatic logic [31:0] pick_float();
        logic [31:0] f;
        case ($urandom_range(0, 3))
            0: f = corner_floats[$urandom_range(0, NUM_CORNERS - 1)];
            1: f = $urandom();
            // Small magnitudes, where the wrap around 360 is exercised most.
            2: f = {1'($urandom), 8'($urandom_range(127, 137)), 23'($urandom)};
            default: f = {1'($urandom), 8'($urandom_range(127, 158)), 23'($urandom)};
        endcase
        return f;
    endfunction

    task automatic queue_frame(input logic [31:0] f);
        bytes_to_send.push_back(ifhe_pkg::HDR_BYTE0);
        bytes_to_send.push_back(ifhe_pkg::HDR_BYTE1);
        bytes_to_send.push_back(ifhe_pkg::HDR_BYTE2);
        bytes_to_send.push_back(ifhe_pkg::HDR_BYTE3);
        for (int i = 0; i < ifhe_pkg::PAYLOAD_BYTES_DEF; i++) begin
            if (i >= ifhe_pkg::FLOAT_OFFSET_DEF && i < ifhe_pkg::FLOAT_OFFSET_DEF + 4)
                bytes_to_send.push_back(f[8 * (ifhe_pkg::FLOAT_OFFSET_DEF + 3 - i) +: 8]);
            else
                bytes_to_send.push_back(8'($urandom));
        end
        // Checksum byte, sometimes a header byte to show it is skipped.
        bytes_to_send.push_back($urandom_range(0, 3) == 0 ? ifhe_pkg::HDR_BYTE0
                                                          : 8'($urandom));
    endtask

    // Driver: offers the queued bytes with random gaps, predicting on each request taken.
    int src_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                advance_parser(s_rx_byte);
                bytes_sent++;
            end
            if (s_valid && !s_ready) begin
                // Hold the request until it is taken.
            end else if (src_gap != 0) begin
                s_valid <= 1'b0;
                src_gap--;
            end else if (bytes_to_send.size() != 0) begin
                s_valid   <= 1'b1;
                s_rx_byte <= bytes_to_send.pop_front();
                src_gap = ((bytes_sent / 64) % 4 == 3) ? 0 : $urandom_range(0, 7);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: random stalls per result, and one long hold-off so the frame queue fills.
    int  sink_stall = 0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;
    always @(posedge aclk) begin
        heading_t exp_h;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                headings_seen++;
                if (expected_headings.size() == 0) begin
                    report_mismatch($sformatf("unexpected heading %0d oor %0b",
                                              m_heading, m_out_of_range));
                end else begin
                    exp_h = expected_headings.pop_front();
                    if (m_heading !== exp_h.deg)
                        report_mismatch($sformatf("heading %0d, expected %0d",
                                                  m_heading, exp_h.deg));
                    if (m_out_of_range !== exp_h.oor)
                        report_mismatch($sformatf("out_of_range %0b, expected %0b",
                                                  m_out_of_range, exp_h.oor));
                end
                sink_stall = ((headings_seen / 8) % 3 == 2) ? 0 : $urandom_range(0, 7);
                if (!hold_done && headings_seen == HOLD_AFTER) begin
                    hold_left = LONG_HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (sink_stall != 0) begin
                m_ready <= 1'b0;
                sink_stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        #200us;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int kind;
        int n;

        // Directed: byte extremes, a mismatch at each header position with restarts,
        // then one complete frame carrying minus one.
        bytes_to_send = '{8'd0, 8'd255, ifhe_pkg::HDR_BYTE0, ifhe_pkg::HDR_BYTE0,
                          ifhe_pkg::HDR_BYTE1, ifhe_pkg::HDR_BYTE0, ifhe_pkg::HDR_BYTE1,
                          ifhe_pkg::HDR_BYTE2, 8'd255};
        queue_frame(32'hBF80_0000);

        while (bytes_to_send.size() < NUM_RANDOM_BYTES + 26) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                queue_frame(pick_float());
            end else if (kind == 7) begin
                // Broken header: a correct prefix, then a random byte.
                n = $urandom_range(1, 3);
                bytes_to_send.push_back(ifhe_pkg::HDR_BYTE0);
                if (n > 1) bytes_to_send.push_back(ifhe_pkg::HDR_BYTE1);
                if (n > 2) bytes_to_send.push_back(ifhe_pkg::HDR_BYTE2);
                bytes_to_send.push_back(8'($urandom));
            end else if (kind == 8) begin
                n = $urandom_range(1, 5);
                repeat (n) bytes_to_send.push_back(8'($urandom));
            end else begin
                // Repeated start bytes ahead of a good frame.
                n = $urandom_range(1, 3);
                repeat (n) bytes_to_send.push_back(ifhe_pkg::HDR_BYTE0);
                queue_frame(pick_float());
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (bytes_to_send.size() != 0 || s_valid || expected_headings.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && expected_headings.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
